[hdl/nomd_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and constants for the nearest-opponent distance block.
// No dependencies; used by the channel interfaces and the top level.
package nomd_pkg;

   // Defaults for board storage
   localparam int MAX_ROWS_DEF = 64;
   localparam int MAX_COLS_DEF = 64;

   // Field widths
   localparam int ROW_W     = 6;
   localparam int COL_W     = 6;
   localparam int CHAR_W    = 8;
   localparam int DIST_W    = 7;
   localparam int STATUS_W  = 2;
   localparam int CSR_ADR_W = 2;
   localparam int CSR_DAT_W = 7;
   localparam int COUNT_W   = 7;
   localparam int PLAYER_W  = 2;
   // Effective board size: holds up to 511, so anything from a 7-bit register
   localparam int EFF_W     = 9;

   // Reset values of the registers
   localparam logic [COUNT_W-1:0]  ROW_COUNT_RST = 7'd64;
   localparam logic [COUNT_W-1:0]  COL_COUNT_RST = 7'd64;
   localparam logic [PLAYER_W-1:0] PLAYER_RST    = 2'd1;

   // Register indexes
   localparam logic [CSR_ADR_W-1:0] CSR_ROW_COUNT = 2'd0;
   localparam logic [CSR_ADR_W-1:0] CSR_COL_COUNT = 2'd1;
   localparam logic [CSR_ADR_W-1:0] CSR_PLAYER    = 2'd2;

   // Player codes
   localparam logic [PLAYER_W-1:0] PLAYER_ONE = 2'd1;
   localparam logic [PLAYER_W-1:0] PLAYER_TWO = 2'd2;

   // Request commands
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Board characters
   localparam logic [CHAR_W-1:0] CHAR_X_LO = 8'h78;
   localparam logic [CHAR_W-1:0] CHAR_X_UP = 8'h58;
   localparam logic [CHAR_W-1:0] CHAR_O_LO = 8'h6F;
   localparam logic [CHAR_W-1:0] CHAR_O_UP = 8'h4F;

   typedef enum logic [1:0] {
      MARK_NONE = 2'd0,
      MARK_O    = 2'd1,
      MARK_X    = 2'd2
   } mark_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_NONE  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   function automatic mark_type classify(input logic [CHAR_W-1:0] ch);
      mark_type m;
      m = MARK_NONE;
      if (ch == CHAR_X_LO || ch == CHAR_X_UP) begin
         m = MARK_X;
      end else if (ch == CHAR_O_LO || ch == CHAR_O_UP) begin
         m = MARK_O;
      end
      return m;
   endfunction

endpackage

[hdl/nomd_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces: request, response and register write.
// Depends on nomd_pkg for field widths.

interface nomd_req_if;
   logic                         valid;
   logic                         ready;
   logic                         command;
   logic [nomd_pkg::ROW_W-1:0]   row_index;
   logic [nomd_pkg::COL_W-1:0]   col_index;
   logic [nomd_pkg::CHAR_W-1:0]  cell_char;

   modport source (output valid, command, row_index, col_index, cell_char, input ready);
   modport sink   (input valid, command, row_index, col_index, cell_char, output ready);
endinterface

interface nomd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [nomd_pkg::DIST_W-1:0]    distance;
   logic [nomd_pkg::STATUS_W-1:0]  status;

   modport source (output valid, distance, status, input ready);
   modport sink   (input valid, distance, status, output ready);
endinterface

interface nomd_csr_if;
   logic                            valid;
   logic                            ready;
   logic [nomd_pkg::CSR_ADR_W-1:0]  addr;
   logic [nomd_pkg::CSR_DAT_W-1:0]  data;

   modport source (output valid, addr, data, input ready);
   modport sink   (input valid, addr, data, output ready);
endinterface

[hdl/nomd_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module nomd_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 4096
) (
   input  logic                                         clock,
   input  logic                                         we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                             wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                             rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

[hdl/nearest_opponent_manhattan_distance.sv]
`timescale 1ns / 1ps
// Top level: board mark memory and nearest-opponent distance scanner.
// Depends on nomd_pkg, the channel interfaces in nomd_if and nomd_ram.
//
//  port      dir   fields                                   moves
//  req_bus   in    command, row_index, col_index, cell_char load or query request
//  rsp_bus   out   distance, status                         one per query
//  csr_bus   in    addr, data                               register write
//
// Sequence: a load is taken in IDLE. A query inside the board is accepted, then
//   reads the rows*cols cells (rows, cols = effective board size), one cell read per
//   cycle over the single memory read port, drains the scan pipeline and publishes
//   from FINISH. An out-of-range query goes straight to FINISH to publish.
// Reset: synchronous, active high. It starts a clearing pass over all
//   MAX_ROWS*MAX_COLS cells that empties each one; requests wait, register
//   writes are taken throughout.
// Stalls: a finished response sits in the output register; new requests are
//   taken while it waits. A second answer waits in FINISH until the slot frees.
module nearest_opponent_manhattan_distance #(
   parameter int MAX_ROWS = nomd_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = nomd_pkg::MAX_COLS_DEF
) (
   input logic          clock,
   input logic          reset,
   nomd_req_if.sink     req_bus,
   nomd_rsp_if.source   rsp_bus,
   nomd_csr_if.sink     csr_bus
);
   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   // Manhattan distance needs one bit more than the wider coordinate
   localparam int DW    = ((RW > CW) ? RW : CW) + 1;
   localparam int EW    = nomd_pkg::EFF_W;

   // ---------------- configuration registers ----------------
   logic [nomd_pkg::COUNT_W-1:0]  row_count_ff, col_count_ff;
   logic [nomd_pkg::PLAYER_W-1:0] player_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= nomd_pkg::ROW_COUNT_RST;
         col_count_ff <= nomd_pkg::COL_COUNT_RST;
         player_ff    <= nomd_pkg::PLAYER_RST;
      end else if (csr_bus.valid) begin
         case (csr_bus.addr)
            nomd_pkg::CSR_ROW_COUNT: row_count_ff <= csr_bus.data;
            nomd_pkg::CSR_COL_COUNT: col_count_ff <= csr_bus.data;
            nomd_pkg::CSR_PLAYER:    player_ff    <= csr_bus.data[nomd_pkg::PLAYER_W-1:0];
            default: ;  // unused index: write dropped
         endcase
      end
   end

   // Effective board size, clipped to storage
   logic [EW-1:0] rows_eff, cols_eff;
   assign rows_eff = (EW'(row_count_ff) < EW'(MAX_ROWS)) ? EW'(row_count_ff) : EW'(MAX_ROWS);
   assign cols_eff = (EW'(col_count_ff) < EW'(MAX_COLS)) ? EW'(col_count_ff) : EW'(MAX_COLS);

   // Opponent mark for the current player; none for player codes 0 and 3
   nomd_pkg::mark_type target;
   logic               target_valid;

   always_comb begin
      target       = nomd_pkg::MARK_X;
      target_valid = 1'b0;
      case (player_ff)
         nomd_pkg::PLAYER_ONE: begin
            target       = nomd_pkg::MARK_X;
            target_valid = 1'b1;
         end
         nomd_pkg::PLAYER_TWO: begin
            target       = nomd_pkg::MARK_O;
            target_valid = 1'b1;
         end
         default: ;
      endcase
   end

   // ---------------- mark memory ----------------
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [1:0]    ram_wdata, ram_rdata;

   nomd_ram #(
      .WIDTH (2),
      .DEPTH (DEPTH)
   ) u_mark_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // ---------------- control state ----------------
   nomd_pkg::state_type state_ff, state_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [RW-1:0] scan_r_ff, scan_r_in;
   logic [CW-1:0] scan_c_ff, scan_c_in;
   logic [RW-1:0] qr_ff, qr_in;           // queried cell
   logic [CW-1:0] qc_ff, qc_in;
   logic          range_ff, range_in;     // query was outside the board
   logic          found_ff, found_in;
   logic [DW-1:0] best_ff, best_in;

   // Scan pipeline: stage 1 sees memory data, stage 2 holds distance
   logic          s1_valid_ff, s1_valid_in;
   logic [RW-1:0] r1_ff;
   logic [CW-1:0] c1_ff;
   logic          s2_valid_ff, s2_valid_in;
   logic          match2_ff, match2_in;
   logic [DW-1:0] d2_ff, d2_in;

   // Response register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [nomd_pkg::DIST_W-1:0]    rsp_dist_ff, rsp_dist_in;
   nomd_pkg::status_type           rsp_status_ff, rsp_status_in;

   logic req_take, issue, rsp_free;
   logic load_in_store, query_in_range;
   logic last_col, last_row;
   logic [RW-1:0] dr;
   logic [CW-1:0] dc;

   assign req_take       = req_bus.valid && req_bus.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_bus.ready;
   assign load_in_store  = (32'(req_bus.row_index) < MAX_ROWS)
                        && (32'(req_bus.col_index) < MAX_COLS);
   assign query_in_range = (EW'(req_bus.row_index) < rows_eff)
                        && (EW'(req_bus.col_index) < cols_eff);
   assign last_col       = (EW'(scan_c_ff) + EW'(1)) == cols_eff;
   assign last_row       = (EW'(scan_r_ff) + EW'(1)) == rows_eff;
   assign ram_raddr      = AW'(scan_r_ff) * AW'(MAX_COLS) + AW'(scan_c_ff);

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      scan_r_in     = scan_r_ff;
      scan_c_in     = scan_c_ff;
      qr_in         = qr_ff;
      qc_in         = qc_ff;
      range_in      = range_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      issue         = 1'b0;
      req_bus.ready = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = AW'(req_bus.row_index) * AW'(MAX_COLS) + AW'(req_bus.col_index);
      ram_wdata     = nomd_pkg::classify(req_bus.cell_char);

      case (state_ff)
         nomd_pkg::ST_CLEAR: begin
            ram_we      = 1'b1;
            ram_waddr   = clr_addr_ff;
            ram_wdata   = nomd_pkg::MARK_NONE;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               state_in = nomd_pkg::ST_IDLE;
            end
         end
         nomd_pkg::ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_take) begin
               if (req_bus.command == nomd_pkg::CMD_LOAD) begin
                  ram_we = load_in_store;
               end else if (query_in_range) begin
                  qr_in     = RW'(req_bus.row_index);
                  qc_in     = CW'(req_bus.col_index);
                  scan_r_in = '0;
                  scan_c_in = '0;
                  found_in  = 1'b0;
                  range_in  = 1'b0;
                  state_in  = nomd_pkg::ST_SCAN;
               end else begin
                  range_in  = 1'b1;
                  state_in  = nomd_pkg::ST_FINISH;
               end
            end
         end
         nomd_pkg::ST_SCAN: begin
            issue = 1'b1;
            if (last_col) begin
               scan_c_in = '0;
               if (last_row) begin
                  state_in = nomd_pkg::ST_DRAIN;
               end else begin
                  scan_r_in = scan_r_ff + RW'(1);
               end
            end else begin
               scan_c_in = scan_c_ff + CW'(1);
            end
         end
         nomd_pkg::ST_DRAIN: begin
            if (!s1_valid_ff && !s2_valid_ff) begin
               state_in = nomd_pkg::ST_FINISH;
            end
         end
         nomd_pkg::ST_FINISH: begin
            if (rsp_free) begin
               state_in = nomd_pkg::ST_IDLE;
            end
         end
         default: state_in = nomd_pkg::ST_IDLE;
      endcase

      // Running minimum over stage 2
      if (s2_valid_ff && match2_ff && (!found_ff || d2_ff < best_ff)) begin
         found_in = 1'b1;
         best_in  = d2_ff;
      end
   end

   // Stage 1 compute: opponent mark, not the queried cell, distance
   assign dr          = (r1_ff > qr_ff) ? (r1_ff - qr_ff) : (qr_ff - r1_ff);
   assign dc          = (c1_ff > qc_ff) ? (c1_ff - qc_ff) : (qc_ff - c1_ff);
   assign s1_valid_in = issue;
   assign s2_valid_in = s1_valid_ff;
   assign match2_in   = target_valid && (ram_rdata == target)
                     && !((r1_ff == qr_ff) && (c1_ff == qc_ff));
   assign d2_in       = DW'(dr) + DW'(dc);

   // Response
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == nomd_pkg::ST_FINISH && rsp_free) begin
         rsp_valid_in = 1'b1;
         if (range_ff) begin
            rsp_dist_in   = '0;
            rsp_status_in = nomd_pkg::STATUS_RANGE;
         end else if (found_ff) begin
            rsp_dist_in   = nomd_pkg::DIST_W'(best_ff);
            rsp_status_in = nomd_pkg::STATUS_OK;
         end else begin
            rsp_dist_in   = '0;
            rsp_status_in = nomd_pkg::STATUS_NONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nomd_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         range_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
         range_ff     <= range_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_r_ff     <= scan_r_in;
      scan_c_ff     <= scan_c_in;
      qr_ff         <= qr_in;
      qc_ff         <= qc_in;
      best_ff       <= best_in;
      r1_ff         <= scan_r_ff;
      c1_ff         <= scan_c_ff;
      match2_ff     <= match2_in;
      d2_ff         <= d2_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.distance = rsp_dist_ff;
   assign rsp_bus.status   = rsp_status_ff;

   // ---------------- checks ----------------
   // Clearing pass keeps requests out right after reset
   a_clear_blocks: assert property (@(posedge clock) reset |=> !req_bus.ready)
      else $error("request taken during clearing pass");

   // A response only appears out of FINISH
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == nomd_pkg::ST_FINISH))
      else $error("response raised outside FINISH");

   // Distance is zero unless the status is ok
   a_dist_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != nomd_pkg::STATUS_OK) |-> rsp_dist_ff == '0)
      else $error("nonzero distance with error status");

   // Stage 2 only follows stage 1
   a_pipe_order: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> $past(s1_valid_ff))
      else $error("scan pipeline out of order");

   // Scan pipeline empty whenever requests are taken
   a_pipe_idle: assert property (@(posedge clock) disable iff (reset)
      req_bus.ready |-> (!s1_valid_ff && !s2_valid_ff))
      else $error("scan still running while idle");
endmodule
